// ===== rtl/fwt2d_pkg.sv =====
// Package for the two-dimensional Fenwick tree block: sizes, codes and the
// structs passed between the channel interfaces, controller, walker and RAM.
// No dependencies.
package fwt2d_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int COORD_W  = 6;
  localparam int CNT_W    = COORD_W + 1;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CFG_W    = 7;
  localparam int DATA_W   = 64;
  localparam int AMT_W    = 32;
  localparam int TYPE_W   = 3;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_SET    = 3'd1,
    REQ_PREFIX = 3'd2,
    REQ_RECT   = 3'd3,
    REQ_RADD   = 3'd4
  } req_e;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PICK,
    ST_WALK,
    ST_DRAIN,
    ST_NEXT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]       req_type;
    logic [COORD_W-1:0]      row_a;
    logic [COORD_W-1:0]      col_a;
    logic [COORD_W-1:0]      row_b;
    logic [COORD_W-1:0]      col_b;
    logic signed [AMT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] total;
    logic                     bad_request;
  } rsp_t;

  typedef struct packed {
    logic               start;
    logic               up;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } walk_cmd_t;

  typedef struct packed {
    logic              issue;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } walk_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== rtl/fwt2d_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on fwt2d_pkg.
interface fwt2d_req_if;
  import fwt2d_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fwt2d_rsp_if;
  import fwt2d_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fwt2d_ram.sv =====
// Tree cell store: one write port, one read port, registered read data.
// Depends on fwt2d_pkg.
module fwt2d_ram (
  input  logic                      clk_i,
  input  fwt2d_pkg::ram_wr_t        wr_i,
  input  logic                      re_i,
  input  logic [fwt2d_pkg::ADDR_W-1:0] raddr_i,
  output logic [fwt2d_pkg::DATA_W-1:0] rdata_o
);
  import fwt2d_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/fwt2d_walk.sv =====
// Index walker: steps the two nested lowbit loops of one tree update or
// prefix query and issues one cell address per cycle. Depends on fwt2d_pkg.
module fwt2d_walk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fwt2d_pkg::walk_cmd_t         cmd_i,
  input  logic [fwt2d_pkg::CNT_W-1:0]  rows_i,
  input  logic [fwt2d_pkg::CNT_W-1:0]  cols_i,
  output fwt2d_pkg::walk_t             walk_o
);
  import fwt2d_pkg::*;

  logic             busy_q, busy_d;
  logic             up_q;
  logic [CNT_W-1:0] i_q, j_q, j0_q;
  logic [CNT_W-1:0] lb_i, lb_j, i_dn, j_dn, i_nx, j_nx, i_m1, j_m1;
  logic [CNT_W:0]   i_up, j_up;
  logic             i_end, j_end;

  always_comb begin
    lb_i  = i_q & (~i_q + 1'b1);
    lb_j  = j_q & (~j_q + 1'b1);
    i_dn  = i_q - lb_i;
    j_dn  = j_q - lb_j;
    i_up  = {1'b0, i_q} + {1'b0, lb_i};
    j_up  = {1'b0, j_q} + {1'b0, lb_j};
    i_end = up_q ? (i_up > {1'b0, rows_i}) : (i_dn == '0);
    j_end = up_q ? (j_up > {1'b0, cols_i}) : (j_dn == '0);
    i_nx  = up_q ? i_up[CNT_W-1:0] : i_dn;
    j_nx  = up_q ? j_up[CNT_W-1:0] : j_dn;
    i_m1  = i_q - 1'b1;
    j_m1  = j_q - 1'b1;
  end

  always_comb begin
    walk_o.issue = busy_q;
    walk_o.last  = busy_q & i_end & j_end;
    walk_o.addr  = {i_m1[COORD_W-1:0], j_m1[COORD_W-1:0]};
    busy_d       = busy_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
    end else if (walk_o.last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      up_q <= cmd_i.up;
      i_q  <= {1'b0, cmd_i.row} + 1'b1;
      j_q  <= {1'b0, cmd_i.col} + 1'b1;
      j0_q <= {1'b0, cmd_i.col} + 1'b1;
    end else if (busy_q) begin
      if (j_end) begin
        j_q <= j0_q;
        i_q <= i_nx;
      end else begin
        j_q <= j_nx;
      end
    end
  end

endmodule

// ===== rtl/fwt2d_ctrl.sv =====
// Request sequencer: checks requests, runs up to four corner walks (plus the
// final update of a point set), accumulates sums and does read-modify-write.
// Depends on fwt2d_pkg.
module fwt2d_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  fwt2d_pkg::req_t               req_i,
  output logic                          req_ready_o,
  input  logic [fwt2d_pkg::CNT_W-1:0]   rows_i,
  input  logic [fwt2d_pkg::CNT_W-1:0]   cols_i,
  output logic                          res_valid_o,
  output fwt2d_pkg::rsp_t               res_o,
  input  logic                          res_take_i,
  output fwt2d_pkg::walk_cmd_t          walk_cmd_o,
  input  fwt2d_pkg::walk_t              walk_i,
  output fwt2d_pkg::ram_wr_t            ram_wr_o,
  input  logic [fwt2d_pkg::DATA_W-1:0]  ram_rdata_i
);
  import fwt2d_pkg::*;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q;
  logic               rd_v_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [1:0]         corner_q;
  logic               upd_q, set_q, query_q, r_ok_q, c_ok_q, bad_q;
  logic [COORD_W-1:0] main_r_q, main_c_q, alt_r_q, alt_c_q;
  logic [DATA_W-1:0]  delta_q, acc_q, acc_nx, wr_data;

  logic               accept, req_bad, type_bad, span_chk, set_switch;
  logic               corner_en, neg;
  logic [COORD_W-1:0] n_main_r, n_main_c, n_alt_r, n_alt_c;
  logic               n_r_ok, n_c_ok;
  logic [CNT_W-1:0]   ra_x, ca_x, rb_x, cb_x, rb_inc, cb_inc;

  always_comb begin
    ra_x     = {1'b0, req_i.row_a};
    ca_x     = {1'b0, req_i.col_a};
    rb_x     = {1'b0, req_i.row_b};
    cb_x     = {1'b0, req_i.col_b};
    rb_inc   = rb_x + 1'b1;
    cb_inc   = cb_x + 1'b1;
    type_bad = 1'b0;
    span_chk = 1'b0;
    n_main_r = req_i.row_a;
    n_main_c = req_i.col_a;
    n_alt_r  = req_i.row_a - 1'b1;
    n_alt_c  = req_i.col_a - 1'b1;
    n_r_ok   = 1'b0;
    n_c_ok   = 1'b0;
    case (req_e'(req_i.req_type)) inside
      REQ_ADD, REQ_PREFIX: begin
      end
      REQ_SET: begin
        n_r_ok = (req_i.row_a != '0);
        n_c_ok = (req_i.col_a != '0);
      end
      REQ_RECT: begin
        span_chk = 1'b1;
        n_main_r = req_i.row_b;
        n_main_c = req_i.col_b;
        n_r_ok   = (req_i.row_a != '0);
        n_c_ok   = (req_i.col_a != '0);
      end
      REQ_RADD: begin
        span_chk = 1'b1;
        n_alt_r  = rb_inc[COORD_W-1:0];
        n_alt_c  = cb_inc[COORD_W-1:0];
        n_r_ok   = (rb_inc < rows_i);
        n_c_ok   = (cb_inc < cols_i);
      end
      default: type_bad = 1'b1;
    endcase
    req_bad = type_bad || (ra_x >= rows_i) || (ca_x >= cols_i) ||
              (span_chk && ((rb_x >= rows_i) || (cb_x >= cols_i) ||
                            (ra_x > rb_x) || (ca_x > cb_x)));
  end

  always_comb begin
    accept     = (state_q == ST_IDLE) && req_valid_i;
    corner_en  = (!corner_q[0] || r_ok_q) && (!corner_q[1] || c_ok_q);
    neg        = corner_q[0] ^ corner_q[1];
    set_switch = (state_q == ST_NEXT) && (corner_q == 2'd3) && set_q;
    acc_nx     = neg ? (acc_q - ram_rdata_i) : (acc_q + ram_rdata_i);
    wr_data    = neg ? (ram_rdata_i - delta_q) : (ram_rdata_i + delta_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (req_valid_i) state_d = req_bad ? ST_RESULT : ST_PICK;
      ST_PICK:   state_d = corner_en ? ST_WALK : ST_NEXT;
      ST_WALK:   if (walk_i.last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_NEXT;
      ST_NEXT: begin
        if (corner_q != 2'd3 || set_q) begin
          state_d = ST_PICK;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: if (res_take_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o      = (state_q == ST_IDLE);
    res_valid_o      = (state_q == ST_RESULT);
    res_o.total      = query_q ? $signed(acc_q) : '0;
    res_o.bad_request = bad_q;
    walk_cmd_o.start = (state_q == ST_PICK) && corner_en;
    walk_cmd_o.up    = upd_q;
    walk_cmd_o.row   = corner_q[0] ? alt_r_q : main_r_q;
    walk_cmd_o.col   = corner_q[1] ? alt_c_q : main_c_q;
    if (state_q == ST_CLEAR) begin
      ram_wr_o.we   = 1'b1;
      ram_wr_o.addr = clr_q;
      ram_wr_o.data = '0;
    end else begin
      ram_wr_o.we   = rd_v_q && upd_q;
      ram_wr_o.addr = rd_addr_q;
      ram_wr_o.data = wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      rd_v_q   <= 1'b0;
      corner_q <= '0;
      upd_q    <= 1'b0;
      set_q    <= 1'b0;
      query_q  <= 1'b0;
      r_ok_q   <= 1'b0;
      c_ok_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= walk_i.issue;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        corner_q <= '0;
        upd_q    <= (req_i.req_type == REQ_ADD) || (req_i.req_type == REQ_RADD);
        set_q    <= (req_i.req_type == REQ_SET) && !req_bad;
        query_q  <= ((req_i.req_type == REQ_PREFIX) || (req_i.req_type == REQ_RECT)) &&
                    !req_bad;
        r_ok_q   <= n_r_ok;
        c_ok_q   <= n_c_ok;
      end else if (set_switch) begin
        corner_q <= '0;
        upd_q    <= 1'b1;
        set_q    <= 1'b0;
        r_ok_q   <= 1'b0;
        c_ok_q   <= 1'b0;
      end else if (state_q == ST_NEXT) begin
        corner_q <= corner_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= walk_i.addr;
    if (accept) begin
      main_r_q <= n_main_r;
      main_c_q <= n_main_c;
      alt_r_q  <= n_alt_r;
      alt_c_q  <= n_alt_c;
      delta_q  <= {{(DATA_W - AMT_W){req_i.amount[AMT_W-1]}}, req_i.amount};
      acc_q    <= '0;
      bad_q    <= req_bad;
    end else begin
      if (set_switch) begin
        delta_q <= delta_q - acc_q;
      end
      if (rd_v_q && !upd_q) begin
        acc_q <= acc_nx;
      end
    end
  end

endmodule

// ===== rtl/fenwick_tree_2d_top.sv =====
// Two-dimensional Fenwick tree of 64-bit wrapping sums, one request at a time.
// Each walked corner reads n tree cells (n <= 49 up, <= 36 down) through the single
// read port; the result waits while the output register is held. Ready for the next
// request rises as the result enters the output register. Reset: rows/cols return
// to 64 and a clearing pass zeroes every tree cell with ready low.
module fenwick_tree_2d_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [fwt2d_pkg::CFG_W-1:0]  cfg_data_i,
  fwt2d_req_if.sink                    req_i,
  fwt2d_rsp_if.source                  rsp_o
);
  import fwt2d_pkg::*;

  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [CNT_W-1:0]  rows_eff, cols_eff;
  logic              res_valid, res_take, out_v_q;
  rsp_t              res, out_q;
  walk_cmd_t         walk_cmd;
  walk_t             walk;
  ram_wr_t           ram_wr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(MAX_ROWS);
      cols_q <= CFG_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rows_q > CFG_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = CNT_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CNT_W'(1);
    end else if (cols_q > CFG_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(cols_q);
    end
  end

  fwt2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req_i.data),
    .req_ready_o (req_i.ready),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .walk_cmd_o  (walk_cmd),
    .walk_i      (walk),
    .ram_wr_o    (ram_wr),
    .ram_rdata_i (ram_rdata)
  );

  fwt2d_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .rows_i (rows_eff),
    .cols_i (cols_eff),
    .walk_o (walk)
  );

  fwt2d_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .re_i    (walk.issue),
    .raddr_i (walk.addr),
    .rdata_o (ram_rdata)
  );

  // hold the result until the output register is free or being emptied
  assign res_take = res_valid && (!out_v_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= res_take || (out_v_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr.we && walk.issue) |-> (ram_wr.addr != walk.addr))
    else $error("read and write hit the same tree cell in one cycle");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request taken while one is in flight");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk.issue |-> (!req_i.ready && !res_valid))
    else $error("walker active outside request processing");

endmodule

// ===== test/fenwick_tree_2d_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fenwick_tree_2d_top: random and directed tree requests
// checked against an in-bench model of the 2-D tree. Depends on fwt2d_pkg and fwt2d_if.
module fenwick_tree_2d_top_test;
  import fwt2d_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 250;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int REQ_W = $bits(req_t);
  localparam logic [TYPE_W-1:0] REQ_UNDEF_FIRST = TYPE_W'(REQ_RADD + 1);
  localparam logic [TYPE_W-1:0] REQ_UNDEF_LAST = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  fwt2d_req_if req_if ();
  fwt2d_rsp_if rsp_if ();

  fenwick_tree_2d_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  logic [DATA_W-1:0] tree_model [DEPTH];
  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;

  req_t requests_to_send [$];
  rsp_t sums_due [$];
  int requests_queued = 0;
  int requests_accepted = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  bit req_taken = 1'b0;
  bit failed = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int live_rows();
    if (rows_cfg == 0) return 1;
    return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
  endfunction

  function automatic int live_cols();
    if (cols_cfg == 0) return 1;
    return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
  endfunction

  function automatic int low_bit(int v);
    return v & -v;
  endfunction

  function automatic void tree_add(int r, int c, logic [DATA_W-1:0] v);
    int i, j, h, w;
    h = live_rows();
    w = live_cols();
    for (i = r + 1; i <= h; i += low_bit(i))
      for (j = c + 1; j <= w; j += low_bit(j))
        tree_model[(i - 1) * MAX_COLS + (j - 1)] += v;
  endfunction

  function automatic logic [DATA_W-1:0] corner_sum(int r, int c);
    logic [DATA_W-1:0] s;
    int i, j;
    s = '0;
    if (r >= live_rows()) r = live_rows() - 1;
    if (c >= live_cols()) c = live_cols() - 1;
    for (i = r + 1; i > 0; i -= low_bit(i))
      for (j = c + 1; j > 0; j -= low_bit(j))
        s += tree_model[(i - 1) * MAX_COLS + (j - 1)];
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] box_sum(int r1, int c1, int r2, int c2);
    logic [DATA_W-1:0] s;
    s = corner_sum(r2, c2);
    if (r1 > 0) s -= corner_sum(r1 - 1, c2);
    if (c1 > 0) s -= corner_sum(r2, c1 - 1);
    if (r1 > 0 && c1 > 0) s += corner_sum(r1 - 1, c1 - 1);
    return s;
  endfunction

  function automatic rsp_t tree_predict(req_t q);
    rsp_t res;
    int h, w, ra, ca, rb, cb;
    logic [DATA_W-1:0] amt;
    h = live_rows();
    w = live_cols();
    ra = q.row_a;
    ca = q.col_a;
    rb = q.row_b;
    cb = q.col_b;
    amt = {{(DATA_W - AMT_W){q.amount[AMT_W-1]}}, q.amount};
    res.total = '0;
    res.bad_request = 1'b0;
    if (q.req_type > REQ_RADD) begin
      res.bad_request = 1'b1;
    end else if (ra >= h || ca >= w) begin
      res.bad_request = 1'b1;
    end else if (q.req_type >= REQ_RECT && (rb >= h || cb >= w || ra > rb || ca > cb)) begin
      res.bad_request = 1'b1;
    end else begin
      case (req_e'(q.req_type))
        REQ_ADD: tree_add(ra, ca, amt);
        REQ_SET: tree_add(ra, ca, amt - box_sum(ra, ca, ra, ca));
        REQ_PREFIX: res.total = corner_sum(ra, ca);
        REQ_RECT: res.total = box_sum(ra, ca, rb, cb);
        default: begin
          tree_add(ra, ca, amt);
          if (rb + 1 < h) tree_add(rb + 1, ca, -amt);
          if (cb + 1 < w) tree_add(ra, cb + 1, -amt);
          if (rb + 1 < h && cb + 1 < w) tree_add(rb + 1, cb + 1, amt);
        end
      endcase
    end
    return res;
  endfunction

  function automatic req_t request(logic [TYPE_W-1:0] kind, int ra, int ca, int rb, int cb,
                                   logic [AMT_W-1:0] amt);
    req_t q;
    q.req_type = kind;
    q.row_a = COORD_W'(ra);
    q.col_a = COORD_W'(ca);
    q.row_b = COORD_W'(rb);
    q.col_b = COORD_W'(cb);
    q.amount = amt;
    return q;
  endfunction

  function automatic logic [AMT_W-1:0] random_amount();
    case ($urandom_range(19))
      0: return {1'b0, {(AMT_W - 1){1'b1}}};
      1: return {1'b1, {(AMT_W - 1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t q;
    int h, w, pick;
    h = live_rows();
    w = live_cols();
    pick = $urandom_range(99);
    q.amount = random_amount();
    q.row_a = COORD_W'($urandom_range(h - 1, 0));
    q.col_a = COORD_W'($urandom_range(w - 1, 0));
    q.row_b = COORD_W'($urandom_range(h - 1, q.row_a));
    q.col_b = COORD_W'($urandom_range(w - 1, q.col_a));
    if (pick < 18) begin
      q.req_type = REQ_ADD;
    end else if (pick < 28) begin
      q.req_type = REQ_SET;
    end else if (pick < 46) begin
      q.req_type = REQ_PREFIX;
    end else if (pick < 70) begin
      q.req_type = REQ_RECT;
    end else if (pick < 88) begin
      q.req_type = REQ_RADD;
    end else if (pick < 91) begin
      q.req_type = TYPE_W'($urandom_range(REQ_UNDEF_LAST, REQ_UNDEF_FIRST));
    end else if (pick < 95 && h > 1) begin
      q.req_type = $urandom_range(1) ? REQ_RECT : REQ_RADD;
      q.row_a = COORD_W'($urandom_range(h - 1, 1));
      q.row_b = COORD_W'($urandom_range(q.row_a - 1, 0));
    end else begin
      q = REQ_W'({$urandom, $urandom});
      q.req_type = TYPE_W'($urandom);
      q.amount = $urandom;
    end
    if (q.req_type < REQ_RECT && $urandom_range(1)) begin
      q.row_b = COORD_W'($urandom);
      q.col_b = COORD_W'($urandom);
    end
    return q;
  endfunction

  task automatic queue_request(req_t q);
    requests_to_send.push_back(q);
    requests_queued++;
  endtask

  task automatic wait_drained();
    while (requests_accepted != requests_queued || sums_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ROWS;
    cfg_data_i <= rows;
    @(negedge clk_i);
    cfg_idx_i <= REG_COLS;
    cfg_data_i <= cols;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rows_cfg = rows;
    cols_cfg = cols;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (requests_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.data <= requests_to_send.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rsp_t due;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (sums_due.size() == 0) begin
          $error("result with none expected: total %0d, bad_request %0b",
                 rsp_if.data.total, rsp_if.data.bad_request);
          failed = 1'b1;
        end else begin
          due = sums_due.pop_front();
          if (rsp_if.data.total !== due.total) begin
            $error("total: expected %0d, got %0d", due.total, rsp_if.data.total);
            failed = 1'b1;
          end
          if (rsp_if.data.bad_request !== due.bad_request) begin
            $error("bad_request: expected %0b, got %0b", due.bad_request,
                   rsp_if.data.bad_request);
            failed = 1'b1;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        sums_due.push_back(tree_predict(req_if.data));
        requests_accepted++;
        req_taken = 1'b1;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    int p, k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROWS;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    rows_cfg = CFG_W'(MAX_ROWS);
    cols_cfg = CFG_W'(MAX_COLS);
    foreach (tree_model[k]) tree_model[k] = '0;
    send_idle_pct = 20;
    recv_idle_pct = 56;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(request(REQ_ADD, 0, 0, 0, 0, 32'h7fff_ffff));
    queue_request(request(REQ_ADD, 63, 63, 0, 0, 32'h8000_0000));
    queue_request(request(REQ_ADD, 63, 0, 63, 63, 32'hffff_ffff));
    queue_request(request(REQ_PREFIX, 63, 63, 0, 0, 32'h0));
    queue_request(request(REQ_SET, 0, 0, 0, 0, 32'h8000_0000));
    queue_request(request(REQ_PREFIX, 0, 0, 63, 63, 32'h0));
    queue_request(request(REQ_RECT, 0, 0, 63, 63, 32'h0));
    queue_request(request(REQ_RADD, 10, 20, 30, 40, 32'd5));
    // corners past the last row and column are skipped
    queue_request(request(REQ_RADD, 0, 0, 63, 63, 32'd7));
    queue_request(request(REQ_RECT, 10, 20, 30, 40, 32'h0));
    queue_request(request(REQ_PREFIX, 30, 40, 0, 0, 32'h0));
    queue_request(request(REQ_RECT, 5, 5, 4, 9, 32'h0));
    queue_request(request(REQ_RADD, 5, 9, 6, 8, 32'd1));
    for (k = REQ_UNDEF_FIRST; k <= REQ_UNDEF_LAST; k++)
      queue_request(request(TYPE_W'(k), 1, 1, 2, 2, 32'd3));
    wait_drained();

    write_grid(7'd8, 7'd8);
    queue_request(request(REQ_ADD, 8, 0, 0, 0, 32'd9));
    queue_request(request(REQ_PREFIX, 0, 8, 0, 0, 32'h0));
    queue_request(request(REQ_RECT, 0, 0, 7, 8, 32'h0));
    queue_request(request(REQ_RADD, 2, 3, 7, 7, 32'd3));
    queue_request(request(REQ_RECT, 0, 0, 7, 7, 32'h0));
    queue_request(request(REQ_SET, 7, 7, 0, 0, 32'd42));
    queue_request(request(REQ_PREFIX, 7, 7, 0, 0, 32'h0));
    queue_request(request(REQ_PREFIX, 63, 63, 63, 63, 32'h0));
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: write_grid(7'd64, 7'd64);
        1: write_grid(7'd1, 7'd1);
        2: write_grid(7'd0, 7'd127);
        3: write_grid(7'd13, 7'd64);
        4: write_grid(7'd127, 7'd2);
        default: write_grid(7'd37, 7'd100);
      endcase
      send_idle_pct = (p < 2) ? 20 : (p < 4) ? 56 : 0;
      recv_idle_pct = (p < 2) ? 56 : (p < 4) ? 20 : 0;
      for (k = 0; k < ITEMS_PER_PHASE; k++) queue_request(random_request());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
